@@ design/als_pkg.sv @@
// shared constants and types for the area light sampler
package als_pkg;

	typedef enum logic [2:0] {
		CFG_MODE      = 3'd0,
		CFG_CORNER    = 3'd1,
		CFG_EDGE_ONE  = 3'd2,
		CFG_EDGE_TWO  = 3'd3,
		CFG_RADIANCE  = 3'd4
	} cfg_idx_t;

	localparam int CFG_IDX_W = 3;
	localparam logic MODE_QUAD = 1'b1;

	localparam int FRAC_BITS = 8;
	localparam int DIR_FRAC = 14;
	localparam int DIR_QW = 15;
	localparam int DIR_W = 16;
	localparam logic [DIR_W-1:0] ONE_Q14 = 16'd16384;

	localparam int DIST_W = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;

	localparam int PDF_QW = 32;
	localparam logic [PDF_QW-1:0] PDF_MAX = 32'hFFFF_FFFF;

	localparam int RAD_W = 48;
	localparam int OUT_TDATA_W = 152;

endpackage

@@ design/als_sqrt.sv @@
// pipelined floor square root, one result bit per stage
module als_sqrt #(
	parameter int IW = 32,
	parameter int PW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [IW-1:0]     rad,
	input  logic [PW-1:0]     pay_in,
	output logic              out_valid,
	output logic [IW/2-1:0]   root,
	output logic [PW-1:0]     pay_out
);
	localparam int RW = IW / 2;
	localparam int REMW = RW + 2;
	localparam int CW = REMW + 2;

	logic            v_s    [RW+1];
	logic [IW-1:0]   x_s    [RW+1];
	logic [REMW-1:0] rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [PW-1:0]   pay_s  [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			pay_s[0]  <= pay_in;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [CW-1:0] cand;
		logic [CW-1:0] trial;
		logic          ge;

		assign cand  = {rem_s[k], x_s[k][IW-1 -: 2]};
		assign trial = CW'({root_s[k], 2'b01});
		assign ge    = cand >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= x_s[k] << 2;
				rem_s[k+1]  <= ge ? REMW'(cand - trial) : REMW'(cand);
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				pay_s[k+1]  <= pay_s[k];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign pay_out   = pay_s[RW];

endmodule

@@ design/als_div.sv @@
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module als_div #(
	parameter int LANES = 1,
	parameter int NW = 40,
	parameter int DW = 26,
	parameter int QW = 15,
	parameter int PW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NW-1:0]    num,
	input  logic [DW-1:0]               den,
	input  logic [PW-1:0]               pay_in,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    quo,
	output logic [LANES-1:0][DW-1:0]    rem,
	output logic [DW-1:0]               den_out,
	output logic [PW-1:0]               pay_out
);
	logic                     v_s   [QW+1];
	logic [LANES-1:0][DW-1:0] r_s   [QW+1];
	logic [LANES-1:0][QW-1:0] q_s   [QW+1];
	logic [LANES-1:0][QW-1:0] n_s   [QW+1];
	logic [DW-1:0]            den_s [QW+1];
	logic [PW-1:0]            pay_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	// partial remainder starts with the numerator bits above the quotient
	for (genvar l = 0; l < LANES; l++) begin : g_load
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[0][l] <= DW'(num[l] >> QW);
				n_s[0][l] <= num[l][QW-1:0];
				q_s[0][l] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			pay_s[0] <= pay_in;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1] <= den_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] t;
			logic [DW:0] dx;
			logic        ge;

			assign t  = {r_s[k][l], n_s[k][l][QW-1]};
			assign dx = {1'b0, den_s[k]};
			assign ge = t >= dx;

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k+1][l] <= ge ? DW'(t - dx) : DW'(t);
					q_s[k+1][l] <= {q_s[k][l][QW-2:0], ge};
					n_s[k+1][l] <= n_s[k][l] << 1;
				end
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign rem       = r_s[QW];
	assign den_out   = den_s[QW];
	assign pay_out   = pay_s[QW];

endmodule

@@ design/area_light_sample_core.sv @@
// area light sampler top level: config registers, sample datapath, output register
//
// channel   dir  payload (lowest bits first)
// cfg       in   cfg_we, cfg_index, cfg_wdata (register value)
// s_axis    in   point_x, point_y, point_z, rand_u, rand_v
// m_axis    out  tdata: dir_x, dir_y, dir_z, distance, pdf, radiance r/g/b; tuser: facing
//
// one request per cycle while m_axis is not stalled
// pipeline depth is set by the two square root pipelines, the 32 step pdf divider and the direction divider
// reset clears the config registers and all stage valid bits
// a stall on m_axis freezes the whole pipeline; s_axis_tready follows it
module area_light_sample_core
	import als_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int RAND_BITS = 16,
	localparam int CFGW = (3 * COORD_BITS > RAD_W) ? 3 * COORD_BITS : RAD_W,
	localparam int INW = ((3 * COORD_BITS + 2 * RAND_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFGW-1:0]        cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// point_x, point_y, point_z, rand_u, rand_v
	input  logic [INW-1:0]         s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// dir_x, dir_y, dir_z, distance, pdf, radiance_r, radiance_g, radiance_b
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// facing
	output logic                   m_axis_tuser
);
	localparam int CB = COORD_BITS;
	localparam int RB = RAND_BITS;
	localparam int P2 = 2 * CB;
	localparam int WW = 2 * RB;
	localparam int PRW = WW + CB + 1;
	localparam int PSW = PRW + 1;
	localparam int DW = CB + 11;
	localparam int NGW = 2 * CB + 1;
	localparam int DPW = 3 * CB + 11;
	localparam int MW = DPW;
	localparam int SQW = 2 * CB + 20;
	localparam int LW = SQW / 2;
	localparam int NUMW = LW + DIR_QW;
	localparam int NW = 3 * LW + 1;
	localparam int CMW = NW + MW + PDF_QW;
	localparam int SH_T = 2 * RB - FRAC_BITS;
	localparam int SH_Q = RB - FRAC_BITS;
	localparam logic [PSW-1:0] RND_T = PSW'(1) << (SH_T - 1);
	localparam logic [PSW-1:0] RND_Q = (SH_Q == 0) ? PSW'(0) : (PSW'(1) << (SH_Q - 1));

	typedef struct packed {
		logic [2:0][NUMW-1:0] num;
		logic [2:0]           sgn;
		logic [DIST_W-1:0]    dst;
		logic [LW-1:0]        len;
		logic [MW-1:0]        mag;
		logic                 fac;
	} tail_t;

	typedef struct packed {
		logic [2:0][NUMW-1:0] num;
		logic [2:0]           sgn;
		logic [DIST_W-1:0]    dst;
		logic [LW-1:0]        len;
		logic                 fac;
		logic                 sat;
	} mid_t;

	typedef struct packed {
		logic [PDF_QW-1:0] pdf;
		logic [DIST_W-1:0] dst;
		logic [2:0]        sgn;
		logic              fac;
	} fin_t;

	function automatic logic signed [CB-1:0] crd(input logic [3*CB-1:0] pk, input int i);
		return pk[i*CB +: CB];
	endfunction

	// config registers
	logic            mode_q;
	logic [3*CB-1:0] corner_q;
	logic [3*CB-1:0] e1_q;
	logic [3*CB-1:0] e2_q;
	logic [RAD_W-1:0] rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			corner_q <= '0;
			e1_q     <= '0;
			e2_q     <= '0;
			rad_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:     mode_q   <= cfg_wdata[0];
				CFG_CORNER:   corner_q <= cfg_wdata[3*CB-1:0];
				CFG_EDGE_ONE: e1_q     <= cfg_wdata[3*CB-1:0];
				CFG_EDGE_TWO: e2_q     <= cfg_wdata[3*CB-1:0];
				CFG_RADIANCE: rad_q    <= cfg_wdata[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	logic quad;
	assign quad = (mode_q == MODE_QUAD);

	// geometric normal, follows the edge registers through the pn_q and then the ng_q registers
	logic signed [P2-1:0]  pn_q [6];
	logic signed [NGW-1:0] ng_q [3];

	always_ff @(posedge clk) begin
		pn_q[0] <= P2'(crd(e1_q, 1)) * P2'(crd(e2_q, 2));
		pn_q[1] <= P2'(crd(e1_q, 2)) * P2'(crd(e2_q, 1));
		pn_q[2] <= P2'(crd(e1_q, 2)) * P2'(crd(e2_q, 0));
		pn_q[3] <= P2'(crd(e1_q, 0)) * P2'(crd(e2_q, 2));
		pn_q[4] <= P2'(crd(e1_q, 0)) * P2'(crd(e2_q, 1));
		pn_q[5] <= P2'(crd(e1_q, 1)) * P2'(crd(e2_q, 0));
		ng_q[0] <= NGW'(pn_q[0]) - NGW'(pn_q[1]);
		ng_q[1] <= NGW'(pn_q[2]) - NGW'(pn_q[3]);
		ng_q[2] <= NGW'(pn_q[4]) - NGW'(pn_q[5]);
	end

	// global pipeline advance
	logic m_valid_q;
	logic en;
	assign en = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11;
	logic sr_v, q_v, pd_v, dv_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= sr_v;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= q_v;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			m_valid_q <= dv_v;
		end
	end

	// s1: input register
	logic [3*CB-1:0] p_s1;
	logic [RB-1:0]   u_s1;
	logic [RB-1:0]   rv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= s_axis_tdata[3*CB-1:0];
			u_s1  <= s_axis_tdata[3*CB +: RB];
			rv_s1 <= s_axis_tdata[3*CB+RB +: RB];
		end
	end

	// sqrt(u) for triangle sampling
	logic [RB-1:0]        su;
	logic [3*CB+2*RB-1:0] sr_pay;

	als_sqrt #(.IW(2 * RB), .PW(3 * CB + 2 * RB)) u_sqrt_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.rad       ({u_s1, {RB{1'b0}}}),
		.pay_in    ({p_s1, u_s1, rv_s1}),
		.out_valid (sr_v),
		.root      (su),
		.pay_out   (sr_pay)
	);

	// s2: edge weights
	logic [RB-1:0] sr_u, sr_rv;
	logic [RB:0]   vc;
	logic [WW-1:0] w1_c, w2_c, w1_s2, w2_s2;
	logic [3*CB-1:0] p_s2, p_s3, p_s4;

	assign sr_u  = sr_pay[RB +: RB];
	assign sr_rv = sr_pay[RB-1:0];
	assign vc    = {1'b1, {RB{1'b0}}} - {1'b0, sr_rv};

	always_comb begin
		if (quad) begin
			w1_c = WW'(sr_u);
			w2_c = WW'(sr_rv);
		end else begin
			w1_c = WW'(su) * WW'(sr_rv);
			w2_c = WW'(su) * WW'(vc);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w1_s2 <= w1_c;
			w2_s2 <= w2_c;
			p_s2  <= sr_pay[2*RB +: 3*CB];
			p_s3  <= p_s2;
			p_s4  <= p_s3;
		end
	end

	// s3..s7: offset, d, squares and dot product per axis
	logic signed [PRW-1:0] pa_s3 [3];
	logic signed [PRW-1:0] pb_s3 [3];
	logic signed [PSW-1:0] t_s4  [3];
	logic signed [DW-1:0]  d_s5  [3];
	logic signed [DW-1:0]  d_s6  [3];
	logic signed [SQW-1:0] sq_s6 [3];
	logic signed [DPW-1:0] dp_s6 [3];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		logic signed [PSW-1:0] off;

		assign off = quad ? (t_s4[i] >>> SH_Q) : (t_s4[i] >>> SH_T);

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s3[i] <= PRW'($signed({1'b0, w1_s2})) * PRW'(crd(e1_q, i));
				pb_s3[i] <= PRW'($signed({1'b0, w2_s2})) * PRW'(crd(e2_q, i));
				t_s4[i]  <= PSW'(pa_s3[i]) + PSW'(pb_s3[i]) + $signed(quad ? RND_Q : RND_T);
				d_s5[i]  <= (DW'(crd(corner_q, i)) <<< FRAC_BITS) + DW'(off)
					- (DW'(crd(p_s4, i)) <<< FRAC_BITS);
				d_s6[i]  <= d_s5[i];
				sq_s6[i] <= SQW'(d_s5[i]) * SQW'(d_s5[i]);
				dp_s6[i] <= DPW'(d_s5[i]) * DPW'(ng_q[i]);
			end
		end
	end

	logic signed [DPW-1:0] dot_c;
	logic [SQW-1:0]        sq_s7;
	logic [3*DW-1:0]       d_s7;
	logic [MW-1:0]         mag_s7;
	logic                  fac_s7;

	assign dot_c = dp_s6[0] + dp_s6[1] + dp_s6[2];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s7  <= SQW'(sq_s6[0] + sq_s6[1] + sq_s6[2]);
			d_s7   <= {d_s6[2], d_s6[1], d_s6[0]};
			fac_s7 <= dot_c < 0;
			mag_s7 <= MW'(-dot_c);
		end
	end

	// length of d
	logic [LW-1:0]        len;
	logic [3*DW+MW:0]     q_pay;

	als_sqrt #(.IW(SQW), .PW(3 * DW + MW + 1)) u_sqrt_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.rad       (sq_s7),
		.pay_in    ({d_s7, mag_s7, fac_s7}),
		.out_valid (q_v),
		.root      (len),
		.pay_out   (q_pay)
	);

	// s8: distance, direction numerators, len squared
	tail_t           tl_c, tl_s8, tl_s9, tl_s10, tl_s11;
	logic [LW:0]     dsum;
	logic [LW:0]     dsh;
	logic [2*LW-1:0] lsq_s8;

	assign dsum = {1'b0, len} + (LW+1)'(1 << (FRAC_BITS - 1));
	assign dsh  = dsum >> FRAC_BITS;

	assign tl_c.len = len;
	assign tl_c.mag = q_pay[MW:1];
	assign tl_c.fac = q_pay[0];
	assign tl_c.dst = (dsh > (LW+1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsh);

	for (genvar i = 0; i < 3; i++) begin : g_num
		logic signed [DW-1:0] di;
		logic signed [DW-1:0] ai;

		assign di = q_pay[MW+1+i*DW +: DW];
		assign ai = di[DW-1] ? -di : di;
		assign tl_c.sgn[i] = di[DW-1];
		assign tl_c.num[i] = (NUMW'($unsigned(ai)) << DIR_FRAC) + NUMW'(len >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tl_s8  <= tl_c;
			lsq_s8 <= (2*LW)'(len) * (2*LW)'(len);
		end
	end

	// s9, s10: cube of length split in two partial products, times two for triangles
	logic [2*LW-1:0] ph_s9, pl_s9;
	logic [NW-1:0]   cube;
	logic [NW-1:0]   n_s10, n_s11;
	logic            sat_s11;

	assign cube = (NW'(ph_s9) << LW) + NW'(pl_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s9   <= (2*LW)'(lsq_s8[2*LW-1:LW]) * (2*LW)'(tl_s8.len);
			pl_s9   <= (2*LW)'(lsq_s8[LW-1:0]) * (2*LW)'(tl_s8.len);
			tl_s9   <= tl_s8;
			n_s10   <= quad ? cube : (cube << 1);
			tl_s10  <= tl_s9;
			n_s11   <= n_s10;
			sat_s11 <= CMW'(n_s10) >= (CMW'(tl_s10.mag) << PDF_QW);
			tl_s11  <= tl_s10;
		end
	end

	// pdf quotient
	mid_t                      pm;
	logic [0:0][PDF_QW-1:0]    pd_q;
	logic [0:0][MW-1:0]        pd_r;
	logic [MW-1:0]             pd_den;
	logic [$bits(mid_t)-1:0]   pd_pay;
	mid_t                      pd_in;
	logic                      pd_rnd;
	logic [PDF_QW-1:0]         pdf_c;

	assign pd_in = '{num: tl_s11.num, sgn: tl_s11.sgn, dst: tl_s11.dst,
		len: tl_s11.len, fac: tl_s11.fac, sat: sat_s11};

	als_div #(.LANES(1), .NW(NW), .DW(MW), .QW(PDF_QW), .PW($bits(mid_t))) u_div_pdf (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.num       (n_s11),
		.den       (tl_s11.mag),
		.pay_in    (pd_in),
		.out_valid (pd_v),
		.quo       (pd_q),
		.rem       (pd_r),
		.den_out   (pd_den),
		.pay_out   (pd_pay)
	);

	assign pm     = pd_pay;
	// round half up: twice the remainder reaches the divisor
	assign pd_rnd = {pd_r[0], 1'b0} >= {1'b0, pd_den};

	always_comb begin
		if (pm.sat || (pd_rnd && pd_q[0] == PDF_MAX)) begin
			pdf_c = PDF_MAX;
		end else begin
			pdf_c = pd_q[0] + PDF_QW'(pd_rnd);
		end
	end

	// direction quotients
	fin_t                      fin_in, fo;
	logic [2:0][DIR_QW-1:0]    dq;
	logic [$bits(fin_t)-1:0]   dv_pay;

	assign fin_in = '{pdf: pdf_c, dst: pm.dst, sgn: pm.sgn, fac: pm.fac};

	als_div #(.LANES(3), .NW(NUMW), .DW(LW), .QW(DIR_QW), .PW($bits(fin_t))) u_div_dir (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pd_v),
		.num       (pm.num),
		.den       (pm.len),
		.pay_in    (fin_in),
		.out_valid (dv_v),
		.quo       (dq),
		.rem       (),
		.den_out   (),
		.pay_out   (dv_pay)
	);

	assign fo = dv_pay;

	// output register
	logic [2:0][DIR_W-1:0] dir_q;
	logic [2:0][DIR_W-1:0] dir_c;
	logic [DIST_W-1:0]     dist_q;
	logic [PDF_QW-1:0]     pdf_q;
	logic [RAD_W-1:0]      rado_q;
	logic                  fac_q;

	for (genvar i = 0; i < 3; i++) begin : g_dir
		logic [DIR_W-1:0] c;

		assign c = (DIR_W'(dq[i]) > ONE_Q14) ? ONE_Q14 : DIR_W'(dq[i]);
		assign dir_c[i] = fo.sgn[i] ? -c : c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fac_q  <= fo.fac;
			dist_q <= fo.dst;
			dir_q  <= fo.fac ? dir_c : '0;
			pdf_q  <= fo.fac ? fo.pdf : '0;
			rado_q <= fo.fac ? rad_q : '0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = fac_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - RAD_W - PDF_QW - DIST_W - 3 * DIR_W)'(0),
		rado_q, pdf_q, dist_q, dir_q};

	// checks
	a_not_facing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !fac_q |-> pdf_q == '0 && rado_q == '0 && dir_q == '0)
		else $error("not facing result carries nonzero payload");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q && $stable(pdf_q) && $stable(dist_q))
		else $error("stalled result dropped or changed");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en |=> v_s1 && $stable(p_s1) && $stable(u_s1))
		else $error("first stage lost its request during stall");

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the area light sampler core
`timescale 1ns / 1ps

module testbench
	import als_pkg::*;
();

	localparam int LAT = 105;
	localparam int WATCH_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [47:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	area_light_sample_core dut (.*);

	always #2 clk = ~clk;

	// local copy of the light registers
	logic        lt_mode = 1'b0;
	logic [47:0] lt_corner = '0, lt_e1 = '0, lt_e2 = '0, lt_rad = '0;

	logic [79:0]  sample_q[$];
	logic [152:0] shadow_q[$];
	bit calm = 0;
	int mismatches = 0, results_seen = 0, facing_seen = 0, send_gap = 0, recv_gap = 0;
	int quiet = 0;

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint crd(logic [47:0] p, int i);
		return longint'($signed(p[16*i +: 16]));
	endfunction

	// expected {facing, tdata} for one shading sample
	function automatic logic [152:0] shade_sample(logic [79:0] req);
		longint w1, w2, x, dotp;
		longint d[3], ng[3];
		longint unsigned u, v, su, sq, len, dst, a, c;
		logic [127:0] num, q, rem;
		int sh;
		logic [OUT_TDATA_W-1:0] o;
		u = req[63:48];
		v = req[79:64];
		if (lt_mode == MODE_QUAD) begin
			w1 = longint'(u);
			w2 = longint'(v);
			sh = 8;
		end else begin
			su = root_floor(u << 16);
			w1 = longint'(su * v);
			w2 = longint'(su * (65536 - v));
			sh = 24;
		end
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			x = w1 * crd(lt_e1, i) + w2 * crd(lt_e2, i);
			x = (x + (64'sd1 <<< (sh - 1))) >>> sh;
			d[i] = crd(lt_corner, i) * 256 + x - longint'($signed(req[16*i +: 16])) * 256;
			sq += longint'(d[i] * d[i]);
		end
		ng[0] = crd(lt_e1, 1) * crd(lt_e2, 2) - crd(lt_e1, 2) * crd(lt_e2, 1);
		ng[1] = crd(lt_e1, 2) * crd(lt_e2, 0) - crd(lt_e1, 0) * crd(lt_e2, 2);
		ng[2] = crd(lt_e1, 0) * crd(lt_e2, 1) - crd(lt_e1, 1) * crd(lt_e2, 0);
		dotp = d[0] * ng[0] + d[1] * ng[1] + d[2] * ng[2];
		len = root_floor(sq);
		dst = (len + 128) >> 8;
		o = '0;
		o[64:48] = (dst > 131071) ? DIST_MAX : dst[16:0];
		if (dotp >= 0) return {1'b0, o};
		for (int i = 0; i < 3; i++) begin
			a = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
			c = (a * 16384 + len / 2) / len;
			if (c > 16384) c = 16384;
			if (d[i] < 0) c = -c;
			o[16*i +: 16] = c[15:0];
		end
		num = 128'(lt_mode == MODE_QUAD ? 1 : 2) * 128'(len) * 128'(len) * 128'(len);
		q = num / 128'(-dotp);
		rem = num % 128'(-dotp);
		if (2 * rem >= 128'(-dotp)) q = q + 1;
		o[96:65] = (q > 128'(PDF_MAX)) ? PDF_MAX : q[31:0];
		o[144:97] = lt_rad;
		return {1'b1, o};
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				shadow_q.push_back(shade_sample(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (sample_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 15);
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= sample_q.pop_front();
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got, inout bit bad);
		if (want !== got) begin
			bad = 1;
			if (mismatches < 10)
				$display("mismatch %s: expected %0h got %0h", name, want, got);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		logic [152:0] w;
		bit bad;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (shadow_q.size() == 0) begin
					if (mismatches < 10) $display("result with nothing outstanding");
					mismatches++;
				end else begin
					w = shadow_q.pop_front();
					bad = 0;
					facing_seen += int'(w[152]);
					check_field("facing", 32'(w[152]), 32'(m_axis_tuser), bad);
					check_field("dir_x", 32'(w[15:0]), 32'(m_axis_tdata[15:0]), bad);
					check_field("dir_y", 32'(w[31:16]), 32'(m_axis_tdata[31:16]), bad);
					check_field("dir_z", 32'(w[47:32]), 32'(m_axis_tdata[47:32]), bad);
					check_field("distance", 32'(w[64:48]), 32'(m_axis_tdata[64:48]), bad);
					check_field("pdf", w[96:65], m_axis_tdata[96:65], bad);
					check_field("radiance_r", 32'(w[112:97]), 32'(m_axis_tdata[112:97]), bad);
					check_field("radiance_g", 32'(w[128:113]), 32'(m_axis_tdata[128:113]),
						bad);
					check_field("radiance_b", 32'(w[144:129]), 32'(m_axis_tdata[144:129]),
						bad);
					if (bad) mismatches++;
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				recv_gap <= $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on stalled traffic
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (sample_q.size() == 0 && shadow_q.size() == 0))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_MODE:     lt_mode = val[0];
			CFG_CORNER:   lt_corner = val;
			CFG_EDGE_ONE: lt_e1 = val;
			CFG_EDGE_TWO: lt_e2 = val;
			CFG_RADIANCE: lt_rad = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || shadow_q.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	task automatic set_light(logic m, logic [47:0] c, logic [47:0] a, logic [47:0] b,
		logic [47:0] r);
		drain();
		write_reg(CFG_MODE, {47'd0, m});
		write_reg(CFG_CORNER, c);
		write_reg(CFG_EDGE_ONE, a);
		write_reg(CFG_EDGE_TWO, b);
		write_reg(CFG_RADIANCE, r);
	endtask

	function automatic logic [47:0] rnd48();
		return 48'({$urandom, $urandom});
	endfunction

	// small coordinates keep the shading point near the light
	function automatic logic [15:0] near();
		return 16'($signed($urandom_range(0, 4095)) - 2048);
	endfunction

	function automatic logic [79:0] rnd_sample();
		if ($urandom_range(0, 2) == 0)
			return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
		return {16'($urandom), 16'($urandom), near(), near(), near()};
	endfunction

	initial begin
		logic [47:0] c, a, b;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// registers at reset: degenerate emitter, never facing
		sample_q.push_back({16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0100});
		sample_q.push_back(80'd0);
		// triangle in the plane z = 256 with its normal up, facing only points above it
		set_light(1'b0, {16'h0100, 16'h0000, 16'h0000}, {16'h0000, 16'h0000, 16'h0100},
			{16'h0000, 16'h0100, 16'h0000}, {16'hFFFF, 16'h8000, 16'h0001});
		sample_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
		sample_q.push_back({16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
		sample_q.push_back({16'h8000, 16'h4000, 16'h0000, 16'h0080, 16'h0080});
		sample_q.push_back({16'h0000, 16'hFFFF, 16'h0200, 16'h0000, 16'h0000});
		// point on the light plane
		sample_q.push_back({16'h4000, 16'h4000, 16'h0100, 16'h0000, 16'h0000});
		// far away extremes: largest distances
		sample_q.push_back({16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000});
		sample_q.push_back({16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
		// huge quad with extreme edges
		set_light(1'b1, {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000},
			{16'h7FFF, 16'h8000, 16'h8000}, 48'hFFFF_FFFF_FFFF);
		for (int i = 0; i < 8; i++)
			sample_q.push_back({16'($urandom), 16'($urandom),
				(i[0] ? 16'h8000 : 16'h7FFF), (i[1] ? 16'h8000 : 16'h7FFF),
				(i[2] ? 16'h8000 : 16'h7FFF)});
		// tiny quad with shading points in its plane, far out along x
		set_light(1'b1, {16'h0000, 16'h0000, 16'h0000}, {16'h0000, 16'h0000, 16'h0001},
			{16'h0000, 16'h0001, 16'h0000}, 48'h0);
		sample_q.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF});
		sample_q.push_back({16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000});
		// random lights, mostly small shapes near the shading points
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 8) begin
				drain();
				calm = 1;
			end
			c = (ph % 3 == 0) ? rnd48() : {near(), near(), near()};
			a = (ph % 3 == 1) ? rnd48() : {near(), near(), near()};
			b = (ph % 3 == 1) ? rnd48() : {near(), near(), near()};
			set_light(ph[0], c, a, b, rnd48());
			for (int i = 0; i < 80; i++) sample_q.push_back(rnd_sample());
		end
		drain();
		$display("covered %0d results, %0d of them facing, over triangle and quad lights",
			results_seen, facing_seen);
		$display("%0d results had field mismatches, %0d left outstanding",
			mismatches, shadow_q.size());
		if (mismatches == 0 && shadow_q.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
